// ----- src/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants, status codes and pipeline structs for the quadratic
// real-root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COEFF_W     = 32;
  localparam int DEG_W       = 8;
  localparam int QUAD_DEGREE = 2;

  // discriminant: b^2 + 4|ac| fits in 2*COEFF_W+2 bits
  localparam int DISC_W  = 2 * COEFF_W + 2;
  localparam int SQRT_W  = DISC_W / 2;
  localparam int SREM_W  = SQRT_W + 4;
  // -b +/- s as signed, and its magnitude
  localparam int NUM_W   = COEFF_W + 3;
  localparam int NMAG_W  = COEFF_W + 2;
  localparam int DIVD_W  = NMAG_W + FRAC_BITS;
  localparam int DVSR_W  = COEFF_W + 1;
  localparam int STAT_W  = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_TWO   = 3'd0,
    ST_ONE   = 3'd1,
    ST_NONE  = 3'd2,
    ST_NOTQ  = 3'd3,
    ST_AZERO = 3'd4
  } status_t;

  typedef struct packed {
    status_t                    status;
    logic signed [COEFF_W-1:0]  a;
    logic signed [COEFF_W-1:0]  b;
  } side_t;

  typedef struct packed {
    status_t                    status;
    logic        [COEFF_W-1:0]  root0;
    logic        [COEFF_W-1:0]  root1;
    logic                       sat0;
    logic                       sat1;
  } result_t;

endpackage

// ----- src/qrs_disc.sv -----
// ----------------------------------------------------------------------------
// qrs_disc
// Two-stage front end: coefficient products, then discriminant and
// early status classification.
// ----------------------------------------------------------------------------
module qrs_disc (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic [qrs_pkg::DEG_W-1:0]             in_degree,
  input  logic signed [qrs_pkg::COEFF_W-1:0]    in_a,
  input  logic signed [qrs_pkg::COEFF_W-1:0]    in_b,
  input  logic signed [qrs_pkg::COEFF_W-1:0]    in_c,
  output logic                                  out_valid,
  output logic [qrs_pkg::DISC_W-1:0]            out_disc,
  output qrs_pkg::side_t                        out_side
);

  localparam int CW = qrs_pkg::COEFF_W;
  localparam int PW = 2 * CW;

  logic [CW-1:0] amag, bmag, cmag;
  logic [PW-1:0] bb_nxt, ac_nxt;
  qrs_pkg::status_t st1_nxt;
  logic acneg_nxt;

  logic                     v1_r, acneg1_r;
  qrs_pkg::status_t         st1_r;
  logic signed [CW-1:0]     a1_r, b1_r;
  logic [PW-1:0]            bb1_r, ac1_r;

  logic [qrs_pkg::DISC_W-1:0] b2e, p4, dsum, ddif, disc_nxt;
  logic                       lt;
  qrs_pkg::status_t           st2_nxt;

  logic                       v2_r;
  logic [qrs_pkg::DISC_W-1:0] disc2_r;
  qrs_pkg::side_t             side2_r;

  always_comb begin
    amag = in_a[CW-1] ? (~in_a + 1'b1) : in_a;
    bmag = in_b[CW-1] ? (~in_b + 1'b1) : in_b;
    cmag = in_c[CW-1] ? (~in_c + 1'b1) : in_c;
    bb_nxt = PW'(bmag) * PW'(bmag);
    ac_nxt = PW'(amag) * PW'(cmag);
    acneg_nxt = (in_a[CW-1] ^ in_c[CW-1]) && (in_c != '0);
    priority if (in_degree != qrs_pkg::DEG_W'(qrs_pkg::QUAD_DEGREE)) begin
      st1_nxt = qrs_pkg::ST_NOTQ;
    end else if (in_a == '0) begin
      st1_nxt = qrs_pkg::ST_AZERO;
    end else begin
      st1_nxt = qrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st1_r    <= st1_nxt;
      acneg1_r <= acneg_nxt;
      a1_r     <= in_a;
      b1_r     <= in_b;
      bb1_r    <= bb_nxt;
      ac1_r    <= ac_nxt;
    end
  end

  always_comb begin
    b2e  = {2'b00, bb1_r};
    p4   = {ac1_r, 2'b00};
    dsum = b2e + p4;
    ddif = b2e - p4;
    lt   = b2e < p4;
    disc_nxt = acneg1_r ? dsum : ddif;
    priority if (st1_r != qrs_pkg::ST_TWO) begin
      st2_nxt = st1_r;
    end else if (!acneg1_r && lt) begin
      st2_nxt = qrs_pkg::ST_NONE;
    end else if (disc_nxt == '0) begin
      st2_nxt = qrs_pkg::ST_ONE;
    end else begin
      st2_nxt = qrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      disc2_r        <= disc_nxt;
      side2_r.status <= st2_nxt;
      side2_r.a      <= a1_r;
      side2_r.b      <= b1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_disc  = disc2_r;
  assign out_side  = side2_r;

endmodule

// ----- src/qrs_sqrt.sv -----
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [qrs_pkg::DISC_W-1:0]      in_disc,
  input  qrs_pkg::side_t                  in_side,
  output logic                            out_valid,
  output logic [qrs_pkg::SQRT_W-1:0]      out_root,
  output qrs_pkg::side_t                  out_side
);

  localparam int NS = qrs_pkg::SQRT_W;
  localparam int XW = qrs_pkg::DISC_W;
  localparam int RW = qrs_pkg::SREM_W;

  logic           v_r    [NS];
  logic [XW-1:0]  x_r    [NS];
  logic [RW-1:0]  rem_r  [NS];
  logic [NS-1:0]  root_r [NS];
  qrs_pkg::side_t side_r [NS];

  logic           v_src    [NS];
  logic [XW-1:0]  x_src    [NS];
  logic [RW-1:0]  rem_src  [NS];
  logic [NS-1:0]  root_src [NS];
  qrs_pkg::side_t side_src [NS];

  logic [RW-1:0]  rem_nxt  [NS];
  logic [NS-1:0]  root_nxt [NS];

  always_comb begin
    v_src[0]    = in_valid;
    x_src[0]    = in_disc;
    rem_src[0]  = '0;
    root_src[0] = '0;
    side_src[0] = in_side;
    for (int k = 1; k < NS; k++) begin
      v_src[k]    = v_r[k-1];
      x_src[k]    = x_r[k-1];
      rem_src[k]  = rem_r[k-1];
      root_src[k] = root_r[k-1];
      side_src[k] = side_r[k-1];
    end
  end

  // each stage brings down the next bit pair, top pair first
  always_comb begin
    logic [RW-1:0] t, trial;
    for (int k = 0; k < NS; k++) begin
      t     = {rem_src[k][RW-3:0], x_src[k][2*(NS-1-k)+1 -: 2]};
      trial = RW'({root_src[k], 2'b01});
      if (t >= trial) begin
        rem_nxt[k]  = t - trial;
        root_nxt[k] = {root_src[k][NS-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = t;
        root_nxt[k] = {root_src[k][NS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < NS; k++) v_r[k] <= v_src[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        x_r[k]    <= x_src[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= side_src[k];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// ----- src/qrs_root.sv -----
// ----------------------------------------------------------------------------
// qrs_root
// Numerator setup, two pipelined restoring dividers (one quotient bit per
// stage), then round-to-nearest and saturation.
// ----------------------------------------------------------------------------
module qrs_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [qrs_pkg::SQRT_W-1:0]    in_sqrt,
  input  qrs_pkg::side_t                in_side,
  output logic                          out_valid,
  output qrs_pkg::result_t              out_res
);

  localparam int CW = qrs_pkg::COEFF_W;
  localparam int NW = qrs_pkg::NUM_W;
  localparam int MW = qrs_pkg::NMAG_W;
  localparam int QW = qrs_pkg::DIVD_W;
  localparam int DW = qrs_pkg::DVSR_W;
  localparam int FB = qrs_pkg::FRAC_BITS;
  localparam int NL = 2;

  // entry stage
  logic signed [NW-1:0] nb, num [NL];
  logic [MW-1:0]        mag [NL];
  logic [CW-1:0]        amag;

  logic                 ve_r;
  qrs_pkg::status_t     ste_r;
  logic [QW-1:0]        ne_r   [NL];
  logic                 nege_r [NL];
  logic [DW-1:0]        de_r;

  always_comb begin
    nb     = -NW'(in_side.b);
    num[0] = nb + NW'(in_sqrt);
    num[1] = nb - NW'(in_sqrt);
    for (int l = 0; l < NL; l++) begin
      mag[l] = num[l][NW-1] ? MW'(-num[l]) : MW'(num[l]);
    end
    amag = in_side.a[CW-1] ? (~in_side.a + 1'b1) : in_side.a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ste_r <= in_side.status;
      de_r  <= {amag, 1'b0};
      for (int l = 0; l < NL; l++) begin
        ne_r[l]   <= {mag[l], FB'(0)};
        nege_r[l] <= (num[l][NW-1] ^ in_side.a[CW-1]) && (num[l] != '0);
      end
    end
  end

  // divider stages
  logic              v_r   [QW];
  qrs_pkg::status_t  st_r  [QW];
  logic [DW-1:0]     d_r   [QW];
  logic [QW-1:0]     n_r   [NL][QW];
  logic              neg_r [NL][QW];
  logic [DW-1:0]     rem_r [NL][QW];
  logic [QW-1:0]     q_r   [NL][QW];

  logic              v_src   [QW];
  qrs_pkg::status_t  st_src  [QW];
  logic [DW-1:0]     d_src   [QW];
  logic [QW-1:0]     n_src   [NL][QW];
  logic              neg_src [NL][QW];
  logic [DW-1:0]     rem_src [NL][QW];
  logic [QW-1:0]     q_src   [NL][QW];

  logic [DW-1:0]     rem_nxt [NL][QW];
  logic [QW-1:0]     q_nxt   [NL][QW];

  always_comb begin
    v_src[0]  = ve_r;
    st_src[0] = ste_r;
    d_src[0]  = de_r;
    for (int l = 0; l < NL; l++) begin
      n_src[l][0]   = ne_r[l];
      neg_src[l][0] = nege_r[l];
      rem_src[l][0] = '0;
      q_src[l][0]   = '0;
    end
    for (int k = 1; k < QW; k++) begin
      v_src[k]  = v_r[k-1];
      st_src[k] = st_r[k-1];
      d_src[k]  = d_r[k-1];
      for (int l = 0; l < NL; l++) begin
        n_src[l][k]   = n_r[l][k-1];
        neg_src[l][k] = neg_r[l][k-1];
        rem_src[l][k] = rem_r[l][k-1];
        q_src[l][k]   = q_r[l][k-1];
      end
    end
  end

  always_comb begin
    logic [DW:0] t, diff;
    for (int l = 0; l < NL; l++) begin
      for (int k = 0; k < QW; k++) begin
        t    = {rem_src[l][k], n_src[l][k][QW-1-k]};
        diff = t - {1'b0, d_src[k]};
        if (t >= {1'b0, d_src[k]}) begin
          rem_nxt[l][k] = diff[DW-1:0];
          q_nxt[l][k]   = {q_src[l][k][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l][k] = t[DW-1:0];
          q_nxt[l][k]   = {q_src[l][k][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < QW; k++) v_r[k] <= v_src[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < QW; k++) begin
        st_r[k] <= st_src[k];
        d_r[k]  <= d_src[k];
        for (int l = 0; l < NL; l++) begin
          n_r[l][k]   <= n_src[l][k];
          neg_r[l][k] <= neg_src[l][k];
          rem_r[l][k] <= rem_nxt[l][k];
          q_r[l][k]   <= q_nxt[l][k];
        end
      end
    end
  end

  // round, saturate, apply sign
  logic [QW:0]    qr  [NL];
  logic [QW:0]    lim [NL];
  logic           sat [NL];
  logic [CW-1:0]  m   [NL];
  logic [CW-1:0]  rt  [NL];
  logic           stat_only;

  always_comb begin
    stat_only = (st_r[QW-1] == qrs_pkg::ST_NONE) || (st_r[QW-1] == qrs_pkg::ST_NOTQ) ||
                (st_r[QW-1] == qrs_pkg::ST_AZERO);
    for (int l = 0; l < NL; l++) begin
      qr[l]  = (QW+1)'(q_r[l][QW-1]) +
               (QW+1)'({rem_r[l][QW-1], 1'b0} >= {1'b0, d_r[QW-1]});
      lim[l] = neg_r[l][QW-1] ? ((QW+1)'(1) << (CW-1))
                              : (((QW+1)'(1) << (CW-1)) - 1'b1);
      sat[l] = qr[l] > lim[l];
      m[l]   = sat[l] ? lim[l][CW-1:0] : qr[l][CW-1:0];
      rt[l]  = neg_r[l][QW-1] ? (~m[l] + 1'b1) : m[l];
      if (stat_only) begin
        rt[l]  = '0;
        sat[l] = 1'b0;
      end
    end
  end

  logic              vf_r;
  qrs_pkg::result_t  res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= v_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.status <= st_r[QW-1];
      res_r.root0  <= rt[0];
      res_r.root1  <= rt[1];
      res_r.sat0   <= sat[0];
      res_r.sat1   <= sat[1];
    end
  end

  assign out_valid = vf_r;
  assign out_res   = res_r;

endmodule

// ----- src/quadratic_real_root_solver_unit.sv -----
// Stages from input transaction to first result: input register,
//   2 product/discriminant stages, 33 square-root stages, 1 setup stage,
//   50 divider stages, 1 rounding stage, output register.
// Throughput: one input per cycle unless the output stalls; output port carries one
//   result per cycle, so a two-root input holds the pipeline for its second root.
// Reset: rst_n synchronous active low clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// quadratic_real_root_solver_unit
// Real roots of a*x^2 + b*x + c in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
module quadratic_real_root_solver_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // coeff_a[31:0], coeff_b[63:32], coeff_c[95:64]
  input  logic [7:0]   in_tuser,   // degree[7:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // root[31:0]
  output logic [3:0]   out_tuser,  // status[2:0], saturated[3]
  output logic         out_tlast
);

  localparam int CW = qrs_pkg::COEFF_W;

  logic adv;

  // input register
  logic                          v0_r;
  logic [qrs_pkg::DEG_W-1:0]     deg0_r;
  logic signed [CW-1:0]          a0_r, b0_r, c0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg0_r <= in_tuser;
      a0_r   <= in_tdata[CW-1:0];
      b0_r   <= in_tdata[2*CW-1:CW];
      c0_r   <= in_tdata[3*CW-1:2*CW];
    end
  end

  logic                          dv;
  logic [qrs_pkg::DISC_W-1:0]    disc;
  qrs_pkg::side_t                dside;

  qrs_disc u_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v0_r),
    .in_degree (deg0_r),
    .in_a      (a0_r),
    .in_b      (b0_r),
    .in_c      (c0_r),
    .out_valid (dv),
    .out_disc  (disc),
    .out_side  (dside)
  );

  logic                          sv;
  logic [qrs_pkg::SQRT_W-1:0]    sroot;
  qrs_pkg::side_t                sside;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (dv),
    .in_disc   (disc),
    .in_side   (dside),
    .out_valid (sv),
    .out_root  (sroot),
    .out_side  (sside)
  );

  logic              rv;
  qrs_pkg::result_t  res;

  qrs_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sv),
    .in_sqrt   (sroot),
    .in_side   (sside),
    .out_valid (rv),
    .out_res   (res)
  );

  // output register; a two-root result goes out as two transactions
  logic              ob_valid_r, ob_second_r;
  qrs_pkg::result_t  ob_res_r;
  logic              cur_last;

  assign cur_last  = (ob_res_r.status != qrs_pkg::ST_TWO) || ob_second_r;
  assign adv       = !ob_valid_r || (out_tready && cur_last);
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r  <= 1'b0;
      ob_second_r <= 1'b0;
    end else if (adv) begin
      ob_valid_r  <= rv;
      ob_second_r <= 1'b0;
    end else if (out_tready) begin
      ob_second_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ob_res_r <= res;
    end
  end

  assign out_tvalid = ob_valid_r;
  assign out_tdata  = ob_second_r ? ob_res_r.root1 : ob_res_r.root0;
  assign out_tuser  = {(ob_second_r ? ob_res_r.sat1 : ob_res_r.sat0), ob_res_r.status};
  assign out_tlast  = cur_last;

`ifndef SYNTHESIS
  a_status_only_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:0] == qrs_pkg::ST_NONE || out_tuser[2:0] == qrs_pkg::ST_NOTQ ||
                   out_tuser[2:0] == qrs_pkg::ST_AZERO)
    |-> out_tlast && out_tdata == '0 && !out_tuser[3])
    else $error("status-only result carries a root");

  a_second_root_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser[2:0] == qrs_pkg::ST_TWO && !out_tlast
    |=> out_tvalid && out_tuser[2:0] == qrs_pkg::ST_TWO && out_tlast)
    else $error("second root missing after first");

  a_hold_on_first_root: assert property (@(posedge clk) disable iff (!rst_n)
    ob_valid_r && !cur_last |-> !in_tready)
    else $error("pipeline advanced while first root pending");
`endif

endmodule

// ----- tb/quadratic_real_root_solver_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_real_root_solver_unit_checker
// Watches both stream channels of the root solver, computes the expected
// roots of each accepted coefficient set and compares every result
// transaction field by field against the oldest expected root.
// ----------------------------------------------------------------------------
module quadratic_real_root_solver_unit_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [95:0]  in_tdata,   // coeff_a[31:0], coeff_b[63:32], coeff_c[95:64]
  input  logic [7:0]   in_tuser,   // degree[7:0]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,  // root[31:0]
  input  logic [3:0]   out_tuser,  // status[2:0], saturated[3]
  input  logic         out_tlast,
  output int           fail_count,
  output int           roots_pending
);

  typedef struct packed {
    logic [31:0]       root;
    qrs_pkg::status_t  status;
    logic              sat;
    logic              last;
  } root_res_t;

  root_res_t expected_roots[$];

  assign roots_pending = expected_roots.size();

  function automatic logic [127:0] isqrt(input logic [127:0] x);
    logic [127:0] res;
    logic [127:0] bitv;
    logic [127:0] t;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv != 0) begin
      t   = res + bitv;
      res = res >> 1;
      if (x >= t) begin
        x   = x - t;
        res = res + bitv;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // (num << FRAC_BITS) / den, rounded half away from zero, clamped to Q16.16
  function automatic root_res_t form_root(input logic signed [39:0] num,
                                          input logic signed [39:0] den,
                                          input qrs_pkg::status_t st, input logic last);
    root_res_t    r;
    logic         neg;
    logic [127:0] mn, md, n, q, rem, lim, m;
    neg = (num < 0) != (den < 0);
    mn  = num < 0 ? 128'(-num) : 128'(num);
    md  = den < 0 ? 128'(-den) : 128'(den);
    n   = mn << qrs_pkg::FRAC_BITS;
    q   = n / md;
    rem = n % md;
    if (2 * rem >= md) q = q + 1;
    lim   = neg ? (128'd1 << 31) : (128'd1 << 31) - 1;
    r.sat = q > lim;
    m     = r.sat ? lim : q;
    if (num == 0) neg = 1'b0;
    r.root   = neg ? 32'(-m) : 32'(m);
    r.status = st;
    r.last   = last;
    return r;
  endfunction

  function automatic void predict_roots(input logic [7:0] deg,
                                        input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic signed [31:0] c);
    root_res_t          so;
    logic [127:0]       ma, mb, mc, b2, p4, disc, s;
    logic signed [39:0] nb, den, sx;
    so = '{root: '0, status: qrs_pkg::ST_NOTQ, sat: 1'b0, last: 1'b1};
    if (deg != qrs_pkg::QUAD_DEGREE) begin
      expected_roots.push_back(so);
      return;
    end
    if (a == 0) begin
      so.status = qrs_pkg::ST_AZERO;
      expected_roots.push_back(so);
      return;
    end
    ma = a < 0 ? 128'(-40'(a)) : 128'(a);
    mb = b < 0 ? 128'(-40'(b)) : 128'(b);
    mc = c < 0 ? 128'(-40'(c)) : 128'(c);
    b2 = mb * mb;
    p4 = (ma * mc) << 2;
    if ((a < 0) != (c < 0) && c != 0) begin
      disc = b2 + p4;
    end else if (b2 < p4) begin
      so.status = qrs_pkg::ST_NONE;
      expected_roots.push_back(so);
      return;
    end else begin
      disc = b2 - p4;
    end
    nb  = -40'(b);
    den = 40'(a) * 2;
    if (disc == 0) begin
      expected_roots.push_back(form_root(nb, den, qrs_pkg::ST_ONE, 1'b1));
    end else begin
      s  = isqrt(disc);
      sx = 40'(s);
      expected_roots.push_back(form_root(nb + sx, den, qrs_pkg::ST_TWO, 1'b0));
      expected_roots.push_back(form_root(nb - sx, den, qrs_pkg::ST_TWO, 1'b1));
    end
  endfunction

  always @(posedge clk) begin
    root_res_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        predict_roots(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64]);
      if (out_tvalid && out_tready) begin
        if (expected_roots.size() == 0) begin
          $error("unexpected result transaction: root %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_roots.pop_front();
          if (out_tdata !== e.root || out_tuser[2:0] !== e.status ||
              out_tuser[3] !== e.sat || out_tlast !== e.last) begin
            fail_count <= fail_count + 1;
            if (out_tdata !== e.root)
              $error("root: expected %h actual %h", e.root, out_tdata);
            if (out_tuser[2:0] !== e.status)
              $error("status: expected %0d actual %0d", e.status, out_tuser[2:0]);
            if (out_tuser[3] !== e.sat)
              $error("saturated: expected %0b actual %0b", e.sat, out_tuser[3]);
            if (out_tlast !== e.last)
              $error("last: expected %0b actual %0b", e.last, out_tlast);
          end
        end
      end
    end
  end

endmodule

// ----- tb/quadratic_real_root_solver_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_real_root_solver_unit_tb
// Drives directed and random coefficient sets into the root solver with
// random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module quadratic_real_root_solver_unit_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [7:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          roots_pending;
  bit          quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quadratic_real_root_solver_unit i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  quadratic_real_root_solver_unit_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .fail_count, .roots_pending
  );

  function automatic int gap_draw();
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_coeffs(input logic [7:0] deg, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] c);
    int gap;
    gap = gap_draw();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= deg;
    in_tdata  <= {c, a, b} == 0 ? '0 : {c, b, a};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] coeff_draw();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 65535)) - 32768);
      2: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
      3: return $urandom_range(0, 3) << $urandom_range(0, 31);
      4: return 32'(int'($urandom_range(1, 64)) * (($urandom() & 1) ? 65536 : -65536));
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  // receiver: random stall before each result transaction
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = gap_draw();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    logic [7:0]  deg;
    logic [31:0] a, b, c;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // not quadratic, zero leading coefficient, no real roots
    send_coeffs(8'd0, 32'h10000, 32'h10000, 32'h10000);
    send_coeffs(8'd3, 32'h10000, 32'h30000, 32'h20000);
    send_coeffs(8'hff, 32'hffffffff, 32'h80000000, 32'h7fffffff);
    send_coeffs(8'd1, 32'h0, 32'h0, 32'h0);
    send_coeffs(8'd2, 32'h0, 32'h10000, 32'h10000);
    send_coeffs(8'd2, 32'h0, 32'h0, 32'h0);
    send_coeffs(8'd2, 32'h10000, 32'h0, 32'h10000);
    send_coeffs(8'd2, 32'h7fffffff, 32'h0, 32'h7fffffff);
    // repeated roots, and a two-root case with c zero
    send_coeffs(8'd2, 32'h10000, 32'h20000, 32'h10000);
    send_coeffs(8'd2, 32'h10000, 32'h0, 32'h0);
    send_coeffs(8'd2, 32'h1, 32'h7fffffff, 32'h0);
    send_coeffs(8'd2, 32'hffff0000, 32'h40000, 32'hfffc0000);
    // two roots, c zero, extremes and saturation
    send_coeffs(8'd2, 32'h10000, 32'hfffd0000, 32'h20000);
    send_coeffs(8'd2, 32'h10000, 32'h30000, 32'h0);
    send_coeffs(8'd2, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_coeffs(8'd2, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_coeffs(8'd2, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_coeffs(8'd2, 32'h1, 32'h80000000, 32'hffffffff);
    send_coeffs(8'd2, 32'hffffffff, 32'h7fffffff, 32'h1);
    send_coeffs(8'd2, 32'h1, 32'h1, 32'h80000000);
    send_coeffs(8'd2, 32'h3, 32'h7, 32'h1);
    for (int i = 0; i < 1000; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      deg = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'd2;
      a = ($urandom_range(0, 19) == 0) ? 32'h0 : coeff_draw();
      b = coeff_draw();
      c = ($urandom_range(0, 9) == 0) ? 32'h0 : coeff_draw();
      // favor real roots: let b dominate often
      if ($urandom_range(0, 2) == 0) begin
        a = 32'($signed(a) >>> $urandom_range(8, 24));
        c = 32'($signed(c) >>> $urandom_range(8, 24));
        if (a == 0) a = 32'h1;
      end
      send_coeffs(deg, a, b, c);
    end
    in_tvalid <= 1'b0;
    quiet = 1'b0;
    while (roots_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/qrs_pkg.sv
src/qrs_disc.sv
src/qrs_sqrt.sv
src/qrs_root.sv
src/quadratic_real_root_solver_unit.sv
tb/quadratic_real_root_solver_unit_checker.sv
tb/quadratic_real_root_solver_unit_tb.sv
